[hw/rtl/assert_macros.svh]
// Assertion macros for the tilt balance controller.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, off during reset.
`define TBC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tbc: property check failed");

// Check that a condition implies a consequence in the same cycle.
`define TBC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tbc: implication check failed");

`endif

[hw/rtl/tbc_pkg.sv]
// Shared types, constants and the arctangent table for the tilt balance controller.
// No dependencies.
package tbc_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 4;
  localparam int LIM_W        = 31;
  localparam int DUTY_W       = 16;
  localparam int NUM_W        = LIM_W + DUTY_W;
  localparam int TILT_W       = 25;
  localparam int PWM_FULL_SCALE_DEF = 2000;

  localparam logic signed [63:0] PITCH_MAX = 64'sd11796480;
  localparam logic signed [63:0] PITCH_MIN = -64'sd11796480;
  localparam logic signed [63:0] CTRL_MAX  = 64'sd140737488355327;
  localparam logic signed [63:0] CTRL_MIN  = -64'sd140737488355328;
  localparam logic signed [63:0] ROUND_HALF = 64'sd32768;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BWD  = 2'd2
  } dir_e;

  typedef enum logic [2:0] {
    REG_GYRO_OFFSET  = 3'd0,
    REG_TARGET_PITCH = 3'd1,
    REG_BLEND_ALPHA  = 3'd2,
    REG_GAIN_NOW     = 3'd3,
    REG_GAIN_PREV    = 3'd4,
    REG_GAIN_PREV2   = 3'd5,
    REG_DRIVE_LIMIT  = 3'd6,
    REG_DEAD_BAND    = 3'd7
  } reg_e;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ_Y, S_SQ_Z, S_SQ_SUM, S_TILT, S_BL_A, S_BL_B, S_BL_SUM,
    S_PITCH, S_PID_A, S_PID_B, S_PID_C, S_PID_SUM, S_ACCUM, S_CLAMP,
    S_BAND, S_DUTY_MUL, S_DIV_GO, S_DIV, S_FINISH
  } state_e;

  typedef enum logic [1:0] {
    CRD_IDLE,
    CRD_SQRT,
    CRD_ROT
  } crd_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  function automatic logic signed [TILT_W-1:0] atan_q16(input logic [STEP_W-1:0] idx);
    logic signed [TILT_W-1:0] val;
    unique case (idx)
      4'd0:    val = 25'sd2949120;
      4'd1:    val = 25'sd1740967;
      4'd2:    val = 25'sd919879;
      4'd3:    val = 25'sd466945;
      4'd4:    val = 25'sd234379;
      4'd5:    val = 25'sd117304;
      4'd6:    val = 25'sd58666;
      4'd7:    val = 25'sd29335;
      4'd8:    val = 25'sd14668;
      4'd9:    val = 25'sd7334;
      4'd10:   val = 25'sd3667;
      4'd11:   val = 25'sd1833;
      4'd12:   val = 25'sd917;
      4'd13:   val = 25'sd458;
      4'd14:   val = 25'sd229;
      default: val = 25'sd115;
    endcase
    return val;
  endfunction

endpackage

[hw/rtl/tilt_balance_controller.sv]
// Tilt balance controller top level: sequencer, state and shared multiplier.
// Depends on tbc_pkg, tbc_mul, tbc_cordic, tbc_div and assert_macros.svh.
//
//   channel | signals                               | transfer
//   in      | in_valid_i/in_ready_o, accel, gyro    | one sample set per item
//   out     | out_valid_o/out_ready_i, four results | one result per item
//   cfg     | cfg_valid_i/cfg_ready_o, index, data  | one register write
//
// An item passes through an accept state, 3 squaring steps, the 16 square root
// and 16 CORDIC steps plus hand-off, 11 blend and PID steps on the shared
// multiplier and an output state; leaving the deadband adds the duty product
// and the 16-step divider.
// Reset restores the register defaults and clears pitch, errors and accumulator.
// A finished result waits in the output register; the next item is accepted meanwhile.
`include "assert_macros.svh"

module tilt_balance_controller #(
  parameter int PWM_FULL_SCALE = tbc_pkg::PWM_FULL_SCALE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic signed [15:0] gyro_x_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         direction_o,
  output logic [10:0]        pwm_duty_o,
  output logic signed [24:0] pitch_out_o,
  output logic signed [31:0] control_out_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  tbc_pkg::state_e state_q, state_d;

  logic signed [15:0] gyro_offset_q;
  logic signed [24:0] target_pitch_q;
  logic [15:0]        blend_alpha_q;
  logic signed [23:0] gain_now_q, gain_prev_q, gain_prev2_q;
  logic [30:0]        drive_limit_q, dead_band_q;

  logic signed [24:0] pitch_q, pitch_d;
  logic signed [25:0] err0_q, err0_d, err1_q, err1_d, err2_q, err2_d;
  logic signed [47:0] ctrl_q, ctrl_d;

  logic signed [15:0] ax_q, ax_d, ay_q, ay_d, az_q, az_d;
  logic signed [26:0] base_q, base_d;
  logic signed [63:0] acc_q, acc_d;
  logic signed [31:0] u_q, u_d;
  logic [30:0]        mag_q, mag_d;
  tbc_pkg::dir_e      dir_q, dir_d;
  logic [10:0]        duty_q, duty_d;

  logic               out_valid_q, out_valid_d;
  tbc_pkg::dir_e      o_dir_q, o_dir_d;
  logic [10:0]        o_duty_q, o_duty_d;
  logic signed [24:0] o_pitch_q, o_pitch_d;
  logic signed [31:0] o_ctrl_q, o_ctrl_d;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic               crd_start, div_start;
  tbc_pkg::unit_sts_t crd_sts, div_sts;
  logic signed [tbc_pkg::TILT_W-1:0] tilt;
  logic [tbc_pkg::DUTY_W-1:0] quo;

  logic [30:0]        lim;
  logic signed [47:0] lim48;
  logic signed [32:0] u33, db33;
  logic signed [16:0] gdiff;
  logic signed [19:0] gstep;
  logic signed [63:0] blend, inc, csum;
  logic signed [24:0] psat;
  logic               in_acc;

  assign lim    = (drive_limit_q == '0) ? 31'd1 : drive_limit_q;
  assign lim48  = $signed({17'b0, lim});
  assign in_acc = in_valid_i && in_ready_o;

  tbc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  tbc_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (crd_start),
    .n_i     (acc_d[31:0]),
    .ax_i    (ax_q),
    .sts_o   (crd_sts),
    .tilt_o  (tilt)
  );

  tbc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod[tbc_pkg::NUM_W-1:0]),
    .den_i   (lim),
    .sts_o   (div_sts),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gyro_offset_q  <= '0;
      target_pitch_q <= '0;
      blend_alpha_q  <= 16'd62259;
      gain_now_q     <= 24'sd163840;
      gain_prev_q    <= -24'sd163840;
      gain_prev2_q   <= '0;
      drive_limit_q  <= 31'd26214400;
      dead_band_q    <= 31'd327680;
    end else if (cfg_valid_i) begin
      unique case (tbc_pkg::reg_e'(cfg_index_i))
        tbc_pkg::REG_GYRO_OFFSET:  gyro_offset_q  <= cfg_data_i[15:0];
        tbc_pkg::REG_TARGET_PITCH: target_pitch_q <= cfg_data_i[24:0];
        tbc_pkg::REG_BLEND_ALPHA:  blend_alpha_q  <= cfg_data_i[15:0];
        tbc_pkg::REG_GAIN_NOW:     gain_now_q     <= cfg_data_i[23:0];
        tbc_pkg::REG_GAIN_PREV:    gain_prev_q    <= cfg_data_i[23:0];
        tbc_pkg::REG_GAIN_PREV2:   gain_prev2_q   <= cfg_data_i[23:0];
        tbc_pkg::REG_DRIVE_LIMIT:  drive_limit_q  <= cfg_data_i[30:0];
        tbc_pkg::REG_DEAD_BAND:    dead_band_q    <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tbc_pkg::S_IDLE;
      pitch_q     <= '0;
      err0_q      <= '0;
      err1_q      <= '0;
      err2_q      <= '0;
      ctrl_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pitch_q     <= pitch_d;
      err0_q      <= err0_d;
      err1_q      <= err1_d;
      err2_q      <= err2_d;
      ctrl_q      <= ctrl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q      <= ax_d;
    ay_q      <= ay_d;
    az_q      <= az_d;
    base_q    <= base_d;
    acc_q     <= acc_d;
    u_q       <= u_d;
    mag_q     <= mag_d;
    dir_q     <= dir_d;
    duty_q    <= duty_d;
    o_dir_q   <= o_dir_d;
    o_duty_q  <= o_duty_d;
    o_pitch_q <= o_pitch_d;
    o_ctrl_q  <= o_ctrl_d;
  end

  always_comb begin
    state_d     = state_q;
    pitch_d     = pitch_q;
    err0_d      = err0_q;
    err1_d      = err1_q;
    err2_d      = err2_q;
    ctrl_d      = ctrl_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    az_d        = az_q;
    base_d      = base_q;
    acc_d       = acc_q;
    u_d         = u_q;
    mag_d       = mag_q;
    dir_d       = dir_q;
    duty_d      = duty_q;
    out_valid_d = out_valid_q && !out_ready_i;
    o_dir_d     = o_dir_q;
    o_duty_d    = o_duty_q;
    o_pitch_d   = o_pitch_q;
    o_ctrl_d    = o_ctrl_q;
    mul_a       = '0;
    mul_b       = '0;
    crd_start   = 1'b0;
    div_start   = 1'b0;
    in_ready_o  = 1'b0;
    gdiff       = 17'(gyro_x_i) - 17'(gyro_offset_q);
    gstep       = (20'(gdiff) <<< 2) + 20'(gdiff);
    blend       = acc_q >>> 16;
    psat        = (blend > tbc_pkg::PITCH_MAX) ? 25'(tbc_pkg::PITCH_MAX) :
                  (blend < tbc_pkg::PITCH_MIN) ? 25'(tbc_pkg::PITCH_MIN) : blend[24:0];
    inc         = acc_q >>> 16;
    csum        = 64'(ctrl_q) + inc;
    u33         = 33'(u_q);
    db33        = $signed({2'b0, dead_band_q});
    unique case (state_q)
      tbc_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ax_d    = accel_x_i;
          ay_d    = accel_y_i;
          az_d    = accel_z_i;
          base_d  = 27'(pitch_q) + 27'(gstep);
          state_d = tbc_pkg::S_SQ_Y;
        end
      end
      tbc_pkg::S_SQ_Y: begin
        mul_a   = 32'(ay_q);
        mul_b   = 32'(ay_q);
        state_d = tbc_pkg::S_SQ_Z;
      end
      tbc_pkg::S_SQ_Z: begin
        mul_a   = 32'(az_q);
        mul_b   = 32'(az_q);
        acc_d   = prod;
        state_d = tbc_pkg::S_SQ_SUM;
      end
      tbc_pkg::S_SQ_SUM: begin
        acc_d     = acc_q + prod;
        crd_start = 1'b1;
        state_d   = tbc_pkg::S_TILT;
      end
      tbc_pkg::S_TILT: begin
        if (crd_sts.done) begin
          state_d = tbc_pkg::S_BL_A;
        end
      end
      tbc_pkg::S_BL_A: begin
        mul_a   = 32'(base_q);
        mul_b   = $signed({16'b0, blend_alpha_q});
        state_d = tbc_pkg::S_BL_B;
      end
      tbc_pkg::S_BL_B: begin
        mul_a   = 32'(tilt);
        mul_b   = $signed({15'b0, 17'(17'h10000 - {1'b0, blend_alpha_q})});
        acc_d   = prod;
        state_d = tbc_pkg::S_BL_SUM;
      end
      tbc_pkg::S_BL_SUM: begin
        acc_d   = acc_q + prod + tbc_pkg::ROUND_HALF;
        state_d = tbc_pkg::S_PITCH;
      end
      tbc_pkg::S_PITCH: begin
        pitch_d = psat;
        err2_d  = err1_q;
        err1_d  = err0_q;
        err0_d  = 26'(target_pitch_q) - 26'(psat);
        state_d = tbc_pkg::S_PID_A;
      end
      tbc_pkg::S_PID_A: begin
        mul_a   = 32'(gain_now_q);
        mul_b   = 32'(err0_q);
        state_d = tbc_pkg::S_PID_B;
      end
      tbc_pkg::S_PID_B: begin
        mul_a   = 32'(gain_prev_q);
        mul_b   = 32'(err1_q);
        acc_d   = prod;
        state_d = tbc_pkg::S_PID_C;
      end
      tbc_pkg::S_PID_C: begin
        mul_a   = 32'(gain_prev2_q);
        mul_b   = 32'(err2_q);
        acc_d   = acc_q + prod;
        state_d = tbc_pkg::S_PID_SUM;
      end
      tbc_pkg::S_PID_SUM: begin
        acc_d   = acc_q + prod + tbc_pkg::ROUND_HALF;
        state_d = tbc_pkg::S_ACCUM;
      end
      tbc_pkg::S_ACCUM: begin
        ctrl_d  = (csum > tbc_pkg::CTRL_MAX) ? 48'(tbc_pkg::CTRL_MAX) :
                  (csum < tbc_pkg::CTRL_MIN) ? 48'(tbc_pkg::CTRL_MIN) : csum[47:0];
        state_d = tbc_pkg::S_CLAMP;
      end
      tbc_pkg::S_CLAMP: begin
        u_d     = (ctrl_q > lim48) ? lim48[31:0] :
                  (ctrl_q < -lim48) ? 32'(-lim48) : ctrl_q[31:0];
        state_d = tbc_pkg::S_BAND;
      end
      tbc_pkg::S_BAND: begin
        mag_d = u_q[31] ? 31'(-u_q) : u_q[30:0];
        priority if (u33 > db33) begin
          dir_d   = tbc_pkg::DIR_FWD;
          state_d = tbc_pkg::S_DUTY_MUL;
        end else if (u33 < -db33) begin
          dir_d   = tbc_pkg::DIR_BWD;
          state_d = tbc_pkg::S_DUTY_MUL;
        end else begin
          dir_d   = tbc_pkg::DIR_STOP;
          duty_d  = '0;
          state_d = tbc_pkg::S_FINISH;
        end
      end
      tbc_pkg::S_DUTY_MUL: begin
        mul_a   = $signed({1'b0, mag_q});
        mul_b   = $signed(32'(PWM_FULL_SCALE));
        state_d = tbc_pkg::S_DIV_GO;
      end
      tbc_pkg::S_DIV_GO: begin
        div_start = 1'b1;
        state_d   = tbc_pkg::S_DIV;
      end
      tbc_pkg::S_DIV: begin
        if (div_sts.done) begin
          duty_d  = quo[10:0];
          state_d = tbc_pkg::S_FINISH;
        end
      end
      tbc_pkg::S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          o_dir_d     = dir_q;
          o_duty_d    = duty_q;
          o_pitch_d   = pitch_q;
          o_ctrl_d    = u_q;
          state_d     = tbc_pkg::S_IDLE;
        end
      end
      default: state_d = tbc_pkg::S_IDLE;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign direction_o   = o_dir_q;
  assign pwm_duty_o    = o_duty_q;
  assign pitch_out_o   = o_pitch_q;
  assign control_out_o = o_ctrl_q;

  `TBC_ASSERT_IMP(a_pitch_range, out_valid_o, (64'(pitch_out_o) <= tbc_pkg::PITCH_MAX) && (64'(pitch_out_o) >= tbc_pkg::PITCH_MIN))
  `TBC_ASSERT_IMP(a_duty_needs_drive, out_valid_o && (pwm_duty_o != 11'd0), direction_o != tbc_pkg::DIR_STOP)
  `TBC_ASSERT_IMP(a_ctrl_clamped, out_valid_o, (48'(control_out_o) <= lim48) && (48'(control_out_o) >= -lim48))
  `TBC_ASSERT(a_busy_after_accept, in_acc |=> !in_ready_o)

endmodule

[hw/rtl/tbc_mul.sv]
// Shared signed 32x32 multiplier with a registered product.
// Depends on nothing.
module tbc_mul (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [63:0] p_o
);

  logic signed [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

[hw/rtl/tbc_cordic.sv]
// Iterative integer square root followed by a vectoring CORDIC for the tilt angle.
// Depends on tbc_pkg.
module tbc_cordic (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [31:0]                        n_i,
  input  logic signed [15:0]                 ax_i,
  output tbc_pkg::unit_sts_t                 sts_o,
  output logic signed [tbc_pkg::TILT_W-1:0]  tilt_o
);

  tbc_pkg::crd_state_e phase_q, phase_d;
  logic [tbc_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d, res_q, res_d;
  logic signed [35:0] x_q, x_d, y_q, y_d;
  logic signed [tbc_pkg::TILT_W-1:0] z_q, z_d;
  logic zero_q, zero_d;
  logic done_q, done_d;
  logic [31:0] bit_v, sum_v;
  logic signed [35:0] dx, dy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tbc_pkg::CRD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    res_q  <= res_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    zero_q <= zero_d;
  end

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    res_d   = res_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    zero_d  = zero_q;
    done_d  = 1'b0;
    bit_v   = 32'h4000_0000 >> {cnt_q, 1'b0};
    sum_v   = res_q + bit_v;
    dx      = y_q >>> cnt_q;
    dy      = x_q >>> cnt_q;
    unique case (phase_q)
      tbc_pkg::CRD_IDLE: begin
        if (start_i) begin
          rem_d   = n_i;
          res_d   = '0;
          y_d     = {{4{ax_i[15]}}, ax_i, 16'b0};
          z_d     = '0;
          zero_d  = (ax_i == 16'sd0);
          cnt_d   = '0;
          phase_d = tbc_pkg::CRD_SQRT;
        end
      end
      tbc_pkg::CRD_SQRT: begin
        if (rem_q >= sum_v) begin
          rem_d = rem_q - sum_v;
          res_d = (res_q >> 1) + bit_v;
        end else begin
          res_d = res_q >> 1;
        end
        x_d   = $signed({3'b0, res_d[16:0], 16'b0});
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 4'(tbc_pkg::CORDIC_STEPS - 1)) begin
          phase_d = tbc_pkg::CRD_ROT;
        end
      end
      tbc_pkg::CRD_ROT: begin
        if (y_q > 36'sd0) begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + tbc_pkg::atan_q16(cnt_q);
        end else begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - tbc_pkg::atan_q16(cnt_q);
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 4'(tbc_pkg::CORDIC_STEPS - 1)) begin
          phase_d = tbc_pkg::CRD_IDLE;
          done_d  = 1'b1;
        end
      end
      default: phase_d = tbc_pkg::CRD_IDLE;
    endcase
  end

  assign sts_o.busy = (phase_q != tbc_pkg::CRD_IDLE);
  assign sts_o.done = done_q;
  assign tilt_o     = zero_q ? '0 : z_q;

endmodule

[hw/rtl/tbc_div.sv]
// Restoring divider for the duty value, one quotient bit per cycle.
// Depends on tbc_pkg.
module tbc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tbc_pkg::NUM_W-1:0]     num_i,
  input  logic [tbc_pkg::LIM_W-1:0]     den_i,
  output tbc_pkg::unit_sts_t            sts_o,
  output logic [tbc_pkg::DUTY_W-1:0]    quo_o
);

  logic busy_q, busy_d, done_q, done_d;
  logic [tbc_pkg::STEP_W-1:0] cnt_q, cnt_d;
  logic [tbc_pkg::LIM_W-1:0] rem_q, rem_d, den_q, den_d;
  logic [tbc_pkg::DUTY_W-1:0] lo_q, lo_d, quo_q, quo_d;
  logic [tbc_pkg::LIM_W:0] trial;
  logic ge;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    lo_q  <= lo_d;
    quo_q <= quo_d;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    lo_d   = lo_q;
    quo_d  = quo_q;
    trial  = {rem_q, lo_q[tbc_pkg::DUTY_W-1]};
    ge     = (trial >= {1'b0, den_q});
    if (!busy_q) begin
      if (start_i) begin
        rem_d  = num_i[tbc_pkg::NUM_W-1:tbc_pkg::DUTY_W];
        lo_d   = num_i[tbc_pkg::DUTY_W-1:0];
        den_d  = den_i;
        quo_d  = '0;
        cnt_d  = '0;
        busy_d = 1'b1;
      end
    end else begin
      rem_d = ge ? tbc_pkg::LIM_W'(trial - {1'b0, den_q}) : trial[tbc_pkg::LIM_W-1:0];
      lo_d  = lo_q << 1;
      quo_d = {quo_q[tbc_pkg::DUTY_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == 4'(tbc_pkg::DUTY_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quo_o      = quo_q;

endmodule
